// ===== design/gfl_pkg.sv =====
// Shared constants and codes for the grouped free-list block allocator.
package gfl_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int GROUP_SIZE_DEF = 50;
  localparam int MAX_RUN_DEF    = 128;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_FORMAT = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

endpackage

// ===== design/grouped_free_list_block_allocator.sv =====
// Top level: sequencer, free stack, link store, in-use marks and request buffer.
//
//   channel | signals                                      | dir
//   req     | req_valid req_ready action block_number run_end | in
//   rsp     | rsp_valid rsp_ready status granted_block free_blocks | out
//
// An allocate that empties the stack loads the next group from the link store, and a free
// into a full stack spills it there; both step one entry at a time through the single
// link-store port and the registered address unit. A rollback releases each buffered block
// in turn, skipping any not in use and spilling whenever the stack is full.
// Format runs an in-use wipe, a chain build and a stack load.
// After reset an in-use wipe runs with req_ready low.
// One item at a time; the next item is taken while a result waits in the output register.
module grouped_free_list_block_allocator #(
  parameter int NUM_BLOCKS = gfl_pkg::NUM_BLOCKS_DEF,
  parameter int GROUP_SIZE = gfl_pkg::GROUP_SIZE_DEF,
  parameter int MAX_RUN    = gfl_pkg::MAX_RUN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [1:0]                      action,
  input  logic [$clog2(NUM_BLOCKS)-1:0]   block_number,
  input  logic                            run_end,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [1:0]                      status,
  output logic [$clog2(NUM_BLOCKS)-1:0]   granted_block,
  output logic [$clog2(NUM_BLOCKS+1)-1:0] free_blocks
);

  localparam int BW    = $clog2(NUM_BLOCKS);
  localparam int FW    = $clog2(NUM_BLOCKS+1);
  localparam int SW    = $clog2(GROUP_SIZE);
  localparam int CW    = $clog2(GROUP_SIZE+1);
  localparam int AW    = $clog2(NUM_BLOCKS*GROUP_SIZE);
  localparam int RCW   = $clog2(MAX_RUN+1);
  localparam int RIW   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int EW    = $clog2(NUM_BLOCKS+GROUP_SIZE+1);
  localparam int FIRST = (NUM_BLOCKS < GROUP_SIZE) ? NUM_BLOCKS : GROUP_SIZE;

  typedef enum logic [18:0] {
    S_WIPE    = 19'b1 << 0,
    S_FG      = 19'b1 << 1,
    S_FG_A    = 19'b1 << 2,
    S_FG_W    = 19'b1 << 3,
    S_FS      = 19'b1 << 4,
    S_IDLE    = 19'b1 << 5,
    S_AL_RD   = 19'b1 << 6,
    S_AL_CNT  = 19'b1 << 7,
    S_LD_A    = 19'b1 << 8,
    S_LD_R    = 19'b1 << 9,
    S_LD_W    = 19'b1 << 10,
    S_AL_FIN  = 19'b1 << 11,
    S_RB      = 19'b1 << 12,
    S_RB_RD   = 19'b1 << 13,
    S_REL_CHK = 19'b1 << 14,
    S_SP_A    = 19'b1 << 15,
    S_SP_W    = 19'b1 << 16,
    S_REL_FIN = 19'b1 << 17,
    S_DONE    = 19'b1 << 18
  } state_t;

  state_t state;

  logic [CW-1:0]  sc;
  logic [FW-1:0]  fc;
  logic [RCW-1:0] rl;
  logic           rf;
  logic           last_r;
  logic           ret_rb;
  logic           fmt;
  logic [1:0]     st_r;
  logic [BW-1:0]  gr_r;
  logic [BW-1:0]  cur;
  logic [BW-1:0]  hi;
  logic [BW-1:0]  base;
  logic [BW-1:0]  wi;
  logic [SW-1:0]  j;
  logic [CW-1:0]  n;
  logic [AW-1:0]  addr_q;

  // memories
  logic [BW-1:0] stk  [GROUP_SIZE];
  logic [BW-1:0] lnk  [NUM_BLOCKS*GROUP_SIZE];
  logic [CW-1:0] lcnt [NUM_BLOCKS];
  logic          used [NUM_BLOCKS];
  logic [BW-1:0] rbuf [MAX_RUN];

  logic [BW-1:0] stk_rd, lnk_rd, rbuf_rd;
  logic [CW-1:0] lcnt_rd;
  logic          use_rd;

  logic          stk_we, lnk_we, lcnt_we, use_we;
  logic [SW-1:0] stk_wa, stk_ra;
  logic [BW-1:0] stk_wd, lnk_wd, lcnt_wa, use_wa, use_ra;
  logic [CW-1:0] lcnt_wd;
  logic          use_wd;
  logic [RIW-1:0] rbuf_ra;

  // format group geometry
  logic [EW-1:0] rem, sz, nxt, nsz, lnk_blk, top;
  always_comb begin
    rem     = EW'(NUM_BLOCKS) - EW'(base);
    sz      = (rem > EW'(GROUP_SIZE)) ? EW'(GROUP_SIZE) : rem;
    lnk_blk = EW'(base) + sz - EW'(1);
    nxt     = EW'(base) + EW'(GROUP_SIZE);
    if (nxt < EW'(NUM_BLOCKS)) begin
      nsz = ((EW'(NUM_BLOCKS) - nxt) > EW'(GROUP_SIZE)) ? EW'(GROUP_SIZE)
            : EW'(NUM_BLOCKS) - nxt;
    end else begin
      nsz = '0;
    end
    top = nxt + nsz - EW'(1);
  end

  logic cur_ok;
  assign cur_ok = (FW'(cur) < FW'(NUM_BLOCKS)) && use_rd;

  gfl_addr_unit #(.NUM_BLOCKS(NUM_BLOCKS), .GROUP_SIZE(GROUP_SIZE)) u_addr (
    .clk  (clk),
    .blk  (cur),
    .idx  (j),
    .addr (addr_q)
  );

  assign req_ready = (state == S_IDLE);

  always_comb begin
    stk_ra  = (state == S_SP_A) ? j : SW'(sc - CW'(1));
    use_ra  = (state == S_IDLE) ? block_number : (state == S_RB_RD) ? rbuf_rd : cur;
    rbuf_ra = RIW'(rl - RCW'(1));

    stk_we = 1'b0; stk_wa = j; stk_wd = lnk_rd;
    case (state)
      S_LD_W:    stk_we = 1'b1;
      S_REL_FIN: begin
        stk_we = 1'b1; stk_wa = sc[SW-1:0]; stk_wd = cur;
      end
      S_FS:      begin
        stk_we = 1'b1; stk_wd = BW'(FIRST - 1) - BW'(j);
      end
      default:   stk_we = 1'b0;
    endcase

    lnk_we = (state == S_SP_W) || (state == S_FG_W);
    lnk_wd = (state == S_SP_W) ? stk_rd : hi - BW'(j);

    lcnt_we = 1'b0; lcnt_wa = cur; lcnt_wd = '0;
    case (state)
      S_REL_CHK: lcnt_we = cur_ok && (sc == '0);
      S_SP_W:    begin
        lcnt_we = (j == SW'(GROUP_SIZE - 1)); lcnt_wd = CW'(GROUP_SIZE);
      end
      S_FG:      begin
        lcnt_we = 1'b1; lcnt_wa = BW'(lnk_blk); lcnt_wd = CW'(nsz);
      end
      default:   lcnt_we = 1'b0;
    endcase

    use_we = 1'b0; use_wa = cur; use_wd = 1'b0;
    case (state)
      S_WIPE:    begin
        use_we = 1'b1; use_wa = wi;
      end
      S_AL_FIN:  begin
        use_we = 1'b1; use_wd = 1'b1;
      end
      S_REL_FIN: use_we = 1'b1;
      default:   use_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    stk_rd <= stk[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk[addr_q] <= lnk_wd;
    end
    lnk_rd <= lnk[addr_q];
  end

  always_ff @(posedge clk) begin
    if (lcnt_we) begin
      lcnt[lcnt_wa] <= lcnt_wd;
    end
    lcnt_rd <= lcnt[stk_rd];
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      used[use_wa] <= use_wd;
    end
    use_rd <= used[use_ra];
  end

  always_ff @(posedge clk) begin
    if (state == S_AL_FIN && rl < RCW'(MAX_RUN)) begin
      rbuf[rl[RIW-1:0]] <= cur;
    end
    rbuf_rd <= rbuf[rbuf_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WIPE;
      wi        <= '0;
      fmt       <= 1'b0;
      sc        <= '0;
      fc        <= '0;
      rl        <= '0;
      rf        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_WIPE: begin
          if (wi == BW'(NUM_BLOCKS - 1)) begin
            wi    <= '0;
            base  <= '0;
            state <= fmt ? S_FG : S_IDLE;
          end else begin
            wi <= wi + BW'(1);
          end
        end
        S_FG: begin
          cur <= BW'(lnk_blk);
          hi  <= BW'(top);
          n   <= CW'(nsz);
          j   <= '0;
          state <= (nsz == '0) ? S_FS : S_FG_A;
        end
        S_FG_A: state <= S_FG_W;
        S_FG_W: begin
          j <= j + SW'(1);
          if (j == SW'(n - CW'(1))) begin
            base  <= base + BW'(GROUP_SIZE);
            state <= S_FG;
          end else begin
            state <= S_FG_A;
          end
        end
        S_FS: begin
          j <= j + SW'(1);
          if (j == SW'(FIRST - 1)) begin
            sc    <= CW'(FIRST);
            fc    <= FW'(NUM_BLOCKS);
            rl    <= '0;
            rf    <= 1'b0;
            state <= S_DONE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            last_r <= run_end;
            gr_r   <= '0;
            ret_rb <= 1'b0;
            cur    <= block_number;
            case (action)
              gfl_pkg::ACT_ALLOC: begin
                if (rf) begin
                  st_r  <= gfl_pkg::ST_REFUSED;
                  if (run_end) begin
                    rf <= 1'b0;
                  end
                  state <= S_DONE;
                end else if (sc == '0) begin
                  st_r  <= gfl_pkg::ST_NOSPACE;
                  state <= S_RB;
                end else begin
                  st_r  <= gfl_pkg::ST_OK;
                  sc    <= sc - CW'(1);
                  state <= S_AL_RD;
                end
              end
              gfl_pkg::ACT_FREE: begin
                st_r  <= gfl_pkg::ST_OK;
                state <= S_REL_CHK;
              end
              gfl_pkg::ACT_FORMAT: begin
                st_r  <= gfl_pkg::ST_OK;
                fmt   <= 1'b1;
                wi    <= '0;
                state <= S_WIPE;
              end
              default: begin
                st_r  <= gfl_pkg::ST_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_AL_RD: begin
          cur   <= stk_rd;
          state <= (sc == '0) ? S_AL_CNT : S_AL_FIN;
        end
        S_AL_CNT: begin
          n <= (lcnt_rd > CW'(GROUP_SIZE)) ? CW'(GROUP_SIZE) : lcnt_rd;
          j <= '0;
          state <= (lcnt_rd == '0) ? S_AL_FIN : S_LD_A;
        end
        S_LD_A: state <= S_LD_R;
        S_LD_R: state <= S_LD_W;
        S_LD_W: begin
          j <= j + SW'(1);
          if (j == SW'(n - CW'(1))) begin
            sc    <= n;
            state <= S_AL_FIN;
          end else begin
            state <= S_LD_A;
          end
        end
        S_AL_FIN: begin
          if (fc != '0) begin
            fc <= fc - FW'(1);
          end
          if (last_r) begin
            rl <= '0;
          end else if (rl < RCW'(MAX_RUN)) begin
            rl <= rl + RCW'(1);
          end
          gr_r  <= cur;
          state <= S_DONE;
        end
        S_RB: begin
          ret_rb <= 1'b1;
          if (rl == '0) begin
            rf    <= !last_r;
            state <= S_DONE;
          end else begin
            rl    <= rl - RCW'(1);
            state <= S_RB_RD;
          end
        end
        S_RB_RD: begin
          cur   <= rbuf_rd;
          state <= S_REL_CHK;
        end
        S_REL_CHK: begin
          j <= '0;
          if (!cur_ok) begin
            state <= ret_rb ? S_RB : S_DONE;
          end else if (sc == CW'(GROUP_SIZE)) begin
            state <= S_SP_A;
          end else begin
            state <= S_REL_FIN;
          end
        end
        S_SP_A: state <= S_SP_W;
        S_SP_W: begin
          j <= j + SW'(1);
          if (j == SW'(GROUP_SIZE - 1)) begin
            sc    <= '0;
            state <= S_REL_FIN;
          end else begin
            state <= S_SP_A;
          end
        end
        S_REL_FIN: begin
          sc    <= sc + CW'(1);
          fc    <= fc + FW'(1);
          state <= ret_rb ? S_RB : S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            status        <= st_r;
            granted_block <= gr_r;
            free_blocks   <= fc;
            fmt           <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sc_range: assert property (@(posedge clk) disable iff (rst) sc <= CW'(GROUP_SIZE))
    else $error("free stack count above group size");

  a_fc_range: assert property (@(posedge clk) disable iff (rst) fc <= FW'(NUM_BLOCKS))
    else $error("free count above block count");

  a_rl_range: assert property (@(posedge clk) disable iff (rst) rl <= RCW'(MAX_RUN))
    else $error("request length above buffer depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_REL_FIN) |-> (sc < CW'(GROUP_SIZE)))
    else $error("push into full free stack");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("accepted item not dispatched");

endmodule

// ===== design/gfl_addr_unit.sv =====
// Shared address unit: registered block * GROUP_SIZE + entry index into the link store.
module gfl_addr_unit #(
  parameter int NUM_BLOCKS = gfl_pkg::NUM_BLOCKS_DEF,
  parameter int GROUP_SIZE = gfl_pkg::GROUP_SIZE_DEF
) (
  input  logic                                     clk,
  input  logic [$clog2(NUM_BLOCKS)-1:0]            blk,
  input  logic [$clog2(GROUP_SIZE)-1:0]            idx,
  output logic [$clog2(NUM_BLOCKS*GROUP_SIZE)-1:0] addr
);

  localparam int AW = $clog2(NUM_BLOCKS*GROUP_SIZE);

  always_ff @(posedge clk) begin
    addr <= AW'(blk * GROUP_SIZE) + AW'(idx);
  end

endmodule
